@@ rtl/ffpd_pkg.sv @@
package ffpd_pkg;

    localparam logic [2:0] PH_NAME   = 3'd0;
    localparam logic [2:0] PH_VALUE  = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_HEX_HI = 3'd3;
    localparam logic [2:0] PH_HEX_LO = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam logic [1:0] ST_FOUND      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
    localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;
    localparam logic [1:0] ST_TOO_LONG   = 2'd3;

    localparam logic [1:0] CFG_KEY_TEXT       = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH     = 2'd1;
    localparam logic [1:0] CFG_VALUE_CAPACITY = 2'd2;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQ      = 8'h3d;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_LA      = 8'h61;
    localparam logic [7:0] CH_LF      = 8'h66;
    localparam logic [7:0] CH_UA      = 8'h41;
    localparam logic [7:0] CH_UF      = 8'h46;

    typedef struct packed {
        logic [2:0] phase;
        logic [3:0] name_pos;
        logic       name_mis;
        logic [7:0] bytes_written;
        logic [3:0] high_nibble;
    } t_search;

    typedef struct packed {
        logic       emit;
        logic [7:0] value_byte;
        logic       done;
        logic [1:0] status;
    } t_result;

    // bit 4 set when the byte is a hex digit, bits 3..0 its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] d;
        logic [4:0] r;
        d = 8'd0;
        r = 5'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_LA && c <= CH_LF) begin
            d = c - CH_LA + 8'd10;
            r = {1'b1, d[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
            r = {1'b1, d[3:0]};
        end
        return r;
    endfunction

endpackage

@@ rtl/ffpd_step.sv @@
module ffpd_step (
    input  ffpd_pkg::t_search i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic [3:0]        i_key_len,
    input  logic [7:0]        i_key_byte,
    input  logic [7:0]        i_cap,
    output ffpd_pkg::t_search o_state,
    output ffpd_pkg::t_result o_result
);

    ffpd_pkg::t_search n_state;
    ffpd_pkg::t_result n_result;
    logic [4:0]        hex;
    logic              full;

    assign hex  = ffpd_pkg::hex_digit(i_byte);
    assign full = i_state.bytes_written >= i_cap;

    always_comb begin
        n_state  = i_state;
        n_result = '0;
        unique case (i_state.phase)
            ffpd_pkg::PH_NAME: begin
                if (i_byte == ffpd_pkg::CH_NUL) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_NOT_FOUND;
                end else if (i_byte == ffpd_pkg::CH_AMP) begin
                    n_state.name_pos = 4'd0;
                    n_state.name_mis = 1'b0;
                end else if (i_byte == ffpd_pkg::CH_EQ) begin
                    if (!i_state.name_mis && i_state.name_pos == i_key_len) begin
                        n_state.phase         = ffpd_pkg::PH_VALUE;
                        n_state.bytes_written = 8'd0;
                    end else begin
                        n_state.phase = ffpd_pkg::PH_SKIP;
                    end
                end else if (i_state.name_pos < i_key_len && i_byte == i_key_byte) begin
                    n_state.name_pos = i_state.name_pos + 4'd1;
                end else begin
                    n_state.name_mis = 1'b1;
                end
            end
            ffpd_pkg::PH_SKIP: begin
                if (i_byte == ffpd_pkg::CH_NUL) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_NOT_FOUND;
                end else if (i_byte == ffpd_pkg::CH_AMP) begin
                    n_state.phase    = ffpd_pkg::PH_NAME;
                    n_state.name_pos = 4'd0;
                    n_state.name_mis = 1'b0;
                end
            end
            ffpd_pkg::PH_VALUE: begin
                if (i_byte == ffpd_pkg::CH_NUL || i_byte == ffpd_pkg::CH_AMP) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_FOUND;
                end else if (i_byte == ffpd_pkg::CH_PERCENT) begin
                    n_state.phase = ffpd_pkg::PH_HEX_HI;
                end else if (full) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_TOO_LONG;
                end else begin
                    n_result.emit       = 1'b1;
                    n_result.value_byte = (i_byte == ffpd_pkg::CH_PLUS) ?
                                          ffpd_pkg::CH_SPACE : i_byte;
                    n_state.bytes_written = i_state.bytes_written + 8'd1;
                end
            end
            ffpd_pkg::PH_HEX_HI: begin
                if (!hex[4]) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_BAD_ESCAPE;
                end else begin
                    n_state.high_nibble = hex[3:0];
                    n_state.phase       = ffpd_pkg::PH_HEX_LO;
                end
            end
            ffpd_pkg::PH_HEX_LO: begin
                if (!hex[4]) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_BAD_ESCAPE;
                end else if (full) begin
                    n_result.done   = 1'b1;
                    n_result.status = ffpd_pkg::ST_TOO_LONG;
                end else begin
                    n_result.emit         = 1'b1;
                    n_result.value_byte   = {i_state.high_nibble, hex[3:0]};
                    n_state.bytes_written = i_state.bytes_written + 8'd1;
                    n_state.phase         = ffpd_pkg::PH_VALUE;
                end
            end
            default: begin
            end
        endcase

        // end of body closes any open search
        if (i_last && !n_result.done && n_state.phase != ffpd_pkg::PH_DONE) begin
            n_result.done = 1'b1;
            if (n_state.phase == ffpd_pkg::PH_VALUE) begin
                n_result.status = ffpd_pkg::ST_FOUND;
            end else if (n_state.phase == ffpd_pkg::PH_HEX_HI ||
                         n_state.phase == ffpd_pkg::PH_HEX_LO) begin
                n_result.status = ffpd_pkg::ST_BAD_ESCAPE;
            end else begin
                n_result.status = ffpd_pkg::ST_NOT_FOUND;
            end
        end
        if (n_result.done) begin
            n_state.phase = ffpd_pkg::PH_DONE;
        end
        if (i_last) begin
            n_state       = '0;
            n_state.phase = ffpd_pkg::PH_NAME;
        end
    end

    assign o_state  = n_state;
    assign o_result = n_result;

endmodule

@@ rtl/form_field_percent_decoder.sv @@
// channel   direction  tdata          tuser / tlast                         handshake
// s_axis    in         form_byte      tlast = last_byte                     tvalid/tready
// m_axis    out        value_byte     tuser = byte_valid, search_done,      tvalid/tready
//                                     status (low bit up)
// cfg       in         i_cfg_data     i_cfg_index selects the register      valid/ready
//
// one form byte per cycle sustained while m_axis is not stalled; a byte is held in the input register,
// then the step logic updates the search state and loads the result register
// a byte that causes no result still passes through both stages
// synchronous active-low reset clears the search state and valid flags and sets the register defaults
// a stalled m_axis holds the result register and the input register, then s_axis
// the cfg channel is always ready
module form_field_percent_decoder #(
    parameter int KEY_BYTES       = 8,
    parameter int MAX_VALUE_BYTES = 255
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // form_byte
    input  logic        s_axis_tlast,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // value_byte
    output logic [3:0]  m_axis_tuser,   // byte_valid, search_done, status[1:0]

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [7:0]        r_key [KEY_BYTES];
    logic [3:0]        r_key_len;
    logic [7:0]        r_cap;

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;

    ffpd_pkg::t_search r_state;
    ffpd_pkg::t_search n_state;
    ffpd_pkg::t_result n_result;

    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [3:0]        r_out_user;

    logic              advance;
    logic [3:0]        klen;
    logic [7:0]        cap;
    logic [7:0]        key_byte;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    assign klen = (r_key_len > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : r_key_len;
    assign cap  = (r_cap > 8'(MAX_VALUE_BYTES)) ? 8'(MAX_VALUE_BYTES) : r_cap;

    always_comb begin
        key_byte = 8'd0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (r_state.name_pos == 4'(i)) begin
                key_byte = r_key[i];
            end
        end
    end

    ffpd_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .i_last     (r_in_last),
        .i_key_len  (klen),
        .i_key_byte (key_byte),
        .i_cap      (cap),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_BYTES; i++) begin
                r_key[i] <= 8'd0;
            end
            r_key_len <= 4'd4;
            r_cap     <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ffpd_pkg::CFG_KEY_TEXT: begin
                    for (int i = 0; i < KEY_BYTES; i++) begin
                        r_key[i] <= i_cfg_data[8*i +: 8];
                    end
                end
                ffpd_pkg::CFG_KEY_LENGTH:     r_key_len <= i_cfg_data[3:0];
                ffpd_pkg::CFG_VALUE_CAPACITY: r_cap     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= '0;
            r_state.phase <= ffpd_pkg::PH_NAME;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_result.emit || n_result.done;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_result.value_byte;
            r_out_user <= {n_result.status, n_result.done, n_result.emit};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tuser  = r_out_user;

endmodule

@@ tb/form_field_percent_decoder_tb.sv @@
`timescale 1ns / 100ps

module form_field_percent_decoder_tb;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;

    class form_scoreboard;
        logic [63:0]       key_text;
        logic [3:0]        key_len;
        logic [7:0]        capacity;
        ffpd_pkg::t_search srch;
        ffpd_pkg::t_result expected_q[$];
        int                errors;

        function new();
            key_text = '0;
            key_len  = 4'd4;
            capacity = 8'd32;
            srch     = '0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] d);
            case (idx)
                ffpd_pkg::CFG_KEY_TEXT:       key_text = d;
                ffpd_pkg::CFG_KEY_LENGTH:     key_len = d[3:0];
                ffpd_pkg::CFG_VALUE_CAPACITY: capacity = d[7:0];
                default: ;
            endcase
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= ffpd_pkg::CH_0 && c <= ffpd_pkg::CH_9)
                return int'(c - ffpd_pkg::CH_0);
            if (c >= ffpd_pkg::CH_LA && c <= ffpd_pkg::CH_LF)
                return int'(c - ffpd_pkg::CH_LA) + 10;
            if (c >= ffpd_pkg::CH_UA && c <= ffpd_pkg::CH_UF)
                return int'(c - ffpd_pkg::CH_UA) + 10;
            return -1;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            int                klen;
            int                h;
            logic              done;
            logic              emit;
            logic [1:0]        st;
            logic [7:0]        ob;
            ffpd_pkg::t_result r;
            klen = (key_len > 4'd8) ? 8 : int'(key_len);
            done = 1'b0;
            emit = 1'b0;
            st   = ffpd_pkg::ST_FOUND;
            ob   = 8'd0;
            case (srch.phase)
                ffpd_pkg::PH_NAME: begin
                    if (b == ffpd_pkg::CH_NUL) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_NOT_FOUND;
                    end else if (b == ffpd_pkg::CH_AMP) begin
                        srch.name_pos = '0;
                        srch.name_mis = 1'b0;
                    end else if (b == ffpd_pkg::CH_EQ) begin
                        if (!srch.name_mis && int'(srch.name_pos) == klen) begin
                            srch.phase         = ffpd_pkg::PH_VALUE;
                            srch.bytes_written = '0;
                        end else begin
                            srch.phase = ffpd_pkg::PH_SKIP;
                        end
                    end else if (int'(srch.name_pos) < klen &&
                                 b == key_text[{srch.name_pos[2:0], 3'b000} +: 8]) begin
                        srch.name_pos = srch.name_pos + 4'd1;
                    end else begin
                        srch.name_mis = 1'b1;
                    end
                end
                ffpd_pkg::PH_SKIP: begin
                    if (b == ffpd_pkg::CH_NUL) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_NOT_FOUND;
                    end else if (b == ffpd_pkg::CH_AMP) begin
                        srch.phase    = ffpd_pkg::PH_NAME;
                        srch.name_pos = '0;
                        srch.name_mis = 1'b0;
                    end
                end
                ffpd_pkg::PH_VALUE: begin
                    if (b == ffpd_pkg::CH_NUL || b == ffpd_pkg::CH_AMP) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_FOUND;
                    end else if (b == ffpd_pkg::CH_PERCENT) begin
                        srch.phase = ffpd_pkg::PH_HEX_HI;
                    end else if (srch.bytes_written >= capacity) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_TOO_LONG;
                    end else begin
                        emit = 1'b1;
                        ob   = (b == ffpd_pkg::CH_PLUS) ? ffpd_pkg::CH_SPACE : b;
                        srch.bytes_written = srch.bytes_written + 8'd1;
                    end
                end
                ffpd_pkg::PH_HEX_HI: begin
                    h = hex_value(b);
                    if (h < 0) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_BAD_ESCAPE;
                    end else begin
                        srch.high_nibble = h[3:0];
                        srch.phase       = ffpd_pkg::PH_HEX_LO;
                    end
                end
                ffpd_pkg::PH_HEX_LO: begin
                    h = hex_value(b);
                    if (h < 0) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_BAD_ESCAPE;
                    end else if (srch.bytes_written >= capacity) begin
                        done = 1'b1;
                        st   = ffpd_pkg::ST_TOO_LONG;
                    end else begin
                        emit = 1'b1;
                        ob   = {srch.high_nibble, h[3:0]};
                        srch.bytes_written = srch.bytes_written + 8'd1;
                        srch.phase         = ffpd_pkg::PH_VALUE;
                    end
                end
                default: ;
            endcase

            // end of body closes an open search
            if (last && !done && srch.phase != ffpd_pkg::PH_DONE) begin
                done = 1'b1;
                if (srch.phase == ffpd_pkg::PH_VALUE)
                    st = ffpd_pkg::ST_FOUND;
                else if (srch.phase == ffpd_pkg::PH_HEX_HI ||
                         srch.phase == ffpd_pkg::PH_HEX_LO)
                    st = ffpd_pkg::ST_BAD_ESCAPE;
                else
                    st = ffpd_pkg::ST_NOT_FOUND;
            end
            if (done) srch.phase = ffpd_pkg::PH_DONE;
            if (last) srch = '0;

            if (emit || done) begin
                r.emit       = emit;
                r.value_byte = ob;
                r.done       = done;
                r.status     = done ? st : ffpd_pkg::ST_FOUND;
                expected_q.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [7:0] data, logic [3:0] user);
            ffpd_pkg::t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual tdata %h tuser %h",
                         $time, data, user);
                return;
            end
            e = expected_q.pop_front();
            compare_field("value_byte", e.value_byte, data);
            compare_field("byte_valid", {7'd0, e.emit}, {7'd0, user[0]});
            compare_field("search_done", {7'd0, e.done}, {7'd0, user[1]});
            compare_field("status", {6'd0, e.status}, {6'd0, user[3:2]});
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // form_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // value_byte
    logic [3:0]  m_axis_tuser;   // byte_valid, search_done, status[1:0]
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    form_scoreboard sb;

    int          idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;
    int          sent_items = 0;
    logic [63:0] cur_key;
    int          cur_len;
    int          cur_cap;
    logic [7:0]  body[$];

    form_field_percent_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver side, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_body();
        for (int i = 0; i < body.size(); i++)
            send_byte(body[i], i == body.size() - 1);
        sent_items += body.size();
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [63:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [63:0] key, input int len, input int cap);
        cfg_write(ffpd_pkg::CFG_KEY_TEXT, key);
        cfg_write(ffpd_pkg::CFG_KEY_LENGTH, 64'(len));
        cfg_write(ffpd_pkg::CFG_VALUE_CAPACITY, 64'(cap));
        i_cfg_valid <= 1'b0;
        cur_key = key;
        cur_len = len;
        cur_cap = cap;
    endtask

    function automatic logic [7:0] random_letter();
        return ffpd_pkg::CH_LA + 8'($urandom_range(25));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
        if (n < 4'd10) return ffpd_pkg::CH_0 + 8'(n);
        return (upper ? ffpd_pkg::CH_UA : ffpd_pkg::CH_LA) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [63:0] random_key(int len);
        logic [63:0] k;
        k = {$urandom, $urandom};
        for (int i = 0; i < len; i++) k[8*i +: 8] = random_letter();
        return k;
    endfunction

    function automatic void push_name();
        int klen;
        int r;
        int n;
        klen = (cur_len > 8) ? 8 : cur_len;
        r = $urandom_range(99);
        if (r < 85)
            for (int i = 0; i < klen; i++) body.push_back(cur_key[8*i +: 8]);
        if (r >= 45 && r < 60 && klen > 0) begin
            n = body.size() - 1 - $urandom_range(klen - 1);
            body[n] = random_letter();
        end else if (r >= 60 && r < 70 && klen > 0) begin
            void'(body.pop_back());
        end else if (r >= 70 && r < 85) begin
            body.push_back(random_letter());
        end else if (r >= 85 && r < 95) begin
            n = $urandom_range(1, 5);
            repeat (n) body.push_back(random_letter());
        end
    endfunction

    function automatic void push_value();
        int          n;
        int          r;
        logic [31:0] v;
        n = $urandom_range(0, (cur_cap < 6) ? cur_cap + 2 : 8);
        repeat (n) begin
            r = $urandom_range(99);
            v = $urandom;
            if (r < 45) begin
                body.push_back(v[0] ? random_letter() :
                               ffpd_pkg::CH_0 + 8'($urandom_range(9)));
            end else if (r < 57) begin
                body.push_back(ffpd_pkg::CH_PLUS);
            end else if (r < 77) begin
                body.push_back(ffpd_pkg::CH_PERCENT);
                body.push_back(hex_char(v[7:4], v[8]));
                body.push_back(hex_char(v[3:0], v[9]));
            end else if (r < 83) begin
                // broken escape
                body.push_back(ffpd_pkg::CH_PERCENT);
                if (v[10]) body.push_back(hex_char(v[7:4], v[8]));
                case ($urandom_range(5))
                    0: body.push_back(ffpd_pkg::CH_LA + 8'd6);
                    1: body.push_back(ffpd_pkg::CH_UA + 8'd6);
                    2: body.push_back(ffpd_pkg::CH_EQ);
                    3: body.push_back(ffpd_pkg::CH_PERCENT);
                    4: body.push_back(ffpd_pkg::CH_AMP);
                    default: body.push_back(8'($urandom_range(128, 255)));
                endcase
            end else if (r < 88) begin
                body.push_back(ffpd_pkg::CH_EQ);
            end else begin
                body.push_back(8'($urandom_range(1, 255)));
            end
        end
    endfunction

    function automatic void build_body();
        int          nf;
        int          r;
        logic [31:0] v;
        body.delete();
        if ($urandom_range(9) == 0) begin
            nf = $urandom_range(1, 12);
            repeat (nf) body.push_back(8'($urandom_range(255)));
            return;
        end
        nf = $urandom_range(1, 4);
        for (int f = 0; f < nf; f++) begin
            if (f > 0) begin
                body.push_back(ffpd_pkg::CH_AMP);
                if ($urandom_range(5) == 0) body.push_back(ffpd_pkg::CH_AMP);
            end
            push_name();
            if ($urandom_range(9) != 0) begin
                body.push_back(ffpd_pkg::CH_EQ);
                push_value();
            end
        end
        r = $urandom_range(99);
        v = $urandom;
        if (r < 5) begin
            body.push_back(ffpd_pkg::CH_NUL);
            body.push_back(random_letter());
        end else if (r < 9) begin
            body.push_back(ffpd_pkg::CH_PERCENT);
        end else if (r < 12) begin
            body.push_back(ffpd_pkg::CH_PERCENT);
            body.push_back(hex_char(v[3:0], v[4]));
        end
        if (body.size() == 0) body.push_back(random_letter());
    endfunction

    initial begin
        int n;
        sb = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = ffpd_pkg::CFG_KEY_TEXT;
        i_cfg_data    = 64'd0;
        cur_key = 64'd0;
        cur_len = 4;
        cur_cap = 32;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key holds zero bytes and never matches
        body = {8'hFF, ffpd_pkg::CH_EQ, 8'h80};
        send_body();
        wait_drain();

        configure({56'd0, ffpd_pkg::CH_LA + 8'd10}, 1, 2);
        // plus, escapes of both cases, too long, swallowed tail
        body = {ffpd_pkg::CH_LA + 8'd10, ffpd_pkg::CH_EQ, ffpd_pkg::CH_PLUS,
                ffpd_pkg::CH_PERCENT, ffpd_pkg::CH_0 + 8'd4, ffpd_pkg::CH_LA,
                ffpd_pkg::CH_PERCENT, ffpd_pkg::CH_0 + 8'd7, ffpd_pkg::CH_UA + 8'd4,
                ffpd_pkg::CH_LA + 8'd25};
        send_body();
        body = {ffpd_pkg::CH_LA + 8'd10, ffpd_pkg::CH_EQ, ffpd_pkg::CH_PERCENT,
                ffpd_pkg::CH_AMP};
        send_body();
        body = {ffpd_pkg::CH_LA + 8'd10, ffpd_pkg::CH_EQ, ffpd_pkg::CH_LA,
                ffpd_pkg::CH_NUL, ffpd_pkg::CH_LA + 8'd16};
        send_body();
        wait_drain();

        sent_items = 0;
        for (int ph = 0; ph < 8 || sent_items < 500; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 20; stall_pct = 20; end
            endcase
            if (ph == 1) begin
                configure({64{1'b1}}, 15, 255);
            end else if (ph == 2) begin
                configure(random_key(8), 0, 6);
            end else if (ph == 3) begin
                configure(random_key(3), 3, 0);
            end else if (ph == 5) begin
                cur_key = random_key(4);
                cur_key[15:8] = ffpd_pkg::CH_NUL;
                configure(cur_key, 4, 8);
            end else begin
                n = $urandom_range(1, 8);
                configure(random_key(n), n, $urandom_range(1, 12));
            end
            if (ph % 4 == 0) hold_left = HOLD_CYCLES;
            if (ph == 1) begin
                // value one byte over the largest capacity
                body.delete();
                repeat (8) body.push_back(8'hFF);
                body.push_back(ffpd_pkg::CH_EQ);
                repeat (256) body.push_back(ffpd_pkg::CH_LA + 8'd23);
                send_body();
            end
            n = 0;
            while (n < 20) begin
                build_body();
                send_body();
                n += body.size();
                if ($urandom_range(15) == 0) wait_drain();
            end
            wait_drain();
        end

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
